@@ design/rfc_pkg.sv @@
// Shared types, constants and codes for the RTU frame CRC checker.
// Used by every module in this folder; depends on nothing else.
package rfc_pkg;

  localparam int unsigned MaxFrameDefault = 256;
  localparam int unsigned CountW          = 9;

  localparam logic [15:0]       CrcInit         = 16'hFFFF;
  localparam logic [15:0]       CrcPoly         = 16'hA001;
  localparam logic [CountW-1:0] RuntLimit       = CountW'(4);
  localparam logic [1:0]        IdOffsetReset   = 2'd0;
  localparam logic [7:0]        ExpectedIdReset = 8'h01;

  typedef enum logic [1:0] {
    CfgIdOffset   = 2'd0,
    CfgExpectedId = 2'd1
  } cfg_index_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StOverflow = 3'd1,
    StRunt     = 3'd2,
    StBadCrc   = 3'd3,
    StWrongId  = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] frame_length;
    logic [7:0]        id_seen;
    logic [15:0]       frames_total;
    logic [15:0]       errors_total;
  } result_t;

  typedef struct packed {
    logic [1:0] id_offset;
    logic [7:0] expected_id;
  } cfg_t;

endpackage

@@ design/rfc_crc_byte.sv @@
// One-byte update of the reflected CRC-16, unrolled over eight bit steps.
// Depends on rfc_pkg for the polynomial.
module rfc_crc_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ rfc_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

@@ design/rfc_frame_tracker.sv @@
// Per-frame state (CRC, trailer hold, count, ID capture) and frame counters.
// Builds the status result at frame end. Depends on rfc_pkg and rfc_crc_byte.
module rfc_frame_tracker #(
  parameter int unsigned MaxFrame = rfc_pkg::MaxFrameDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  rfc_pkg::in_t     item_i,
  input  rfc_pkg::cfg_t    cfg_i,
  output rfc_pkg::result_t result_o
);

  localparam logic [rfc_pkg::CountW-1:0] MaxCnt = rfc_pkg::CountW'(MaxFrame);

  logic [15:0]                 crc_q, crc_d, crc_fold;
  logic [1:0][7:0]             held_q, held_d;
  logic [rfc_pkg::CountW-1:0]  count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic [7:0]                  id_q, id_d;
  logic [15:0]                 frames_q, frames_d;
  logic [15:0]                 errors_q, errors_d;
  logic                        keep;
  rfc_pkg::status_e            status;

  rfc_crc_byte u_crc (
    .crc_i  (crc_q),
    .data_i (held_q[0]),
    .crc_o  (crc_fold)
  );

  always_comb begin
    // drop the byte once the frame is full
    keep      = count_q < MaxCnt;
    crc_d     = (keep && count_q >= rfc_pkg::CountW'(2)) ? crc_fold : crc_q;
    held_d[0] = keep ? held_q[1] : held_q[0];
    held_d[1] = keep ? item_i.rx_byte : held_q[1];
    id_d      = (keep && count_q == rfc_pkg::CountW'(cfg_i.id_offset)) ?
                item_i.rx_byte : id_q;
    count_d   = keep ? count_q + rfc_pkg::CountW'(1) : count_q;
    ovf_d     = ovf_q | ~keep;
    frames_d  = frames_q + 16'd1;

    priority if (ovf_d) begin
      status = rfc_pkg::StOverflow;
    end else if (count_d < rfc_pkg::RuntLimit) begin
      status = rfc_pkg::StRunt;
    end else if (held_d[0] != crc_d[7:0] || held_d[1] != crc_d[15:8]) begin
      status = rfc_pkg::StBadCrc;
    end else if (id_d != cfg_i.expected_id) begin
      status = rfc_pkg::StWrongId;
    end else begin
      status = rfc_pkg::StOk;
    end

    errors_d = (status != rfc_pkg::StOk) ? errors_q + 16'd1 : errors_q;

    result_o.status       = status;
    result_o.frame_length = count_d;
    result_o.id_seen      = id_d;
    result_o.frames_total = frames_d;
    result_o.errors_total = errors_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= rfc_pkg::CrcInit;
      held_q   <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      id_q     <= '0;
      frames_q <= '0;
      errors_q <= '0;
    end else if (step_i) begin
      if (item_i.frame_end) begin
        // clear per-frame state, keep the counters
        crc_q    <= rfc_pkg::CrcInit;
        held_q   <= '0;
        count_q  <= '0;
        ovf_q    <= 1'b0;
        id_q     <= '0;
        frames_q <= frames_d;
        errors_q <= errors_d;
      end else begin
        crc_q   <= crc_d;
        held_q  <= held_d;
        count_q <= count_d;
        ovf_q   <= ovf_d;
        id_q    <= id_d;
      end
    end
  end

endmodule

@@ design/rtu_frame_crc_checker.sv @@
// RTU frame CRC checker: takes one received byte per request, tagged with a
// frame-end flag, and returns one status result per frame (ok, overflow,
// runt, bad CRC, wrong ID) with length, captured ID and wrapping counters.
// A byte is held in the input register until the frame tracker takes it. When
// the tracker takes a frame's last byte, that frame's result loads into the
// output register and is valid from there. The single-byte
// CRC update in the tracker is the longest path. A new byte is taken every
// cycle. The input stalls only while the input register holds a frame end
// and the output register holds a result that is not taken in that cycle.
// Configuration writes are taken at once. Depends on rfc_pkg and
// rfc_frame_tracker.
module rtu_frame_crc_checker #(
  parameter int unsigned MaxFrame = rfc_pkg::MaxFrameDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rfc_pkg::in_t     in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rfc_pkg::result_t out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i
);

  logic             in_valid_q;
  rfc_pkg::in_t     in_q;
  logic             out_valid_q;
  rfc_pkg::result_t out_q;
  rfc_pkg::result_t result;
  rfc_pkg::cfg_t    cfg_q;
  logic             step;

  // a byte that ends no frame never waits on the output
  assign step = in_valid_q && (!in_q.frame_end || !out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  rfc_frame_tracker #(
    .MaxFrame (MaxFrame)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q.id_offset   <= rfc_pkg::IdOffsetReset;
      cfg_q.expected_id <= rfc_pkg::ExpectedIdReset;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step && in_q.frame_end) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rfc_pkg::CfgIdOffset:   cfg_q.id_offset   <= cfg_data_i[1:0];
          rfc_pkg::CfgExpectedId: cfg_q.expected_id <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
    if (step && in_q.frame_end) begin
      out_q <= result;
    end
  end

  a_no_result_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_q.frame_end) |-> (!out_valid_q || out_ready_i))
    else $error("frame result written over an untaken result");

  a_ok_not_runt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status == rfc_pkg::StOk) |->
      (out_o.frame_length >= rfc_pkg::RuntLimit))
    else $error("ok status on a runt frame");

  a_held_byte_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_q)))
    else $error("stalled input byte lost or changed");

endmodule
